// ----- design/mqtt_publish_packet_parser_top_defines.svh -----
// Assertion macros for the MQTT publish packet parser.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef MQTT_PUBLISH_PACKET_PARSER_TOP_DEFINES_SVH
`define MQTT_PUBLISH_PACKET_PARSER_TOP_DEFINES_SVH

// Same-cycle implication.
`define MQTTPP_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MQTTPP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/mqttpp_pkg.sv -----
// ----------------------------------------------------------------------------
// MQTT publish packet parser package
// Byte kinds, error codes, header constants and field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mqttpp_pkg;

	localparam logic [2:0] MAX_LENGTH_BYTES = 3'd4;
	localparam logic [7:0] PUBLISH_HEADER   = 8'h30;
	localparam int         IN_TDATA_W       = 8;
	localparam int         OUT_TDATA_W      = 112;
	localparam int         OUT_TUSER_W      = 3;

	typedef enum logic [2:0] {
		KIND_HEADER  = 3'd0,
		KIND_LENGTH  = 3'd1,
		KIND_TLEN    = 3'd2,
		KIND_TOPIC   = 3'd3,
		KIND_PAYLOAD = 3'd4,
		KIND_IGNORED = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE        = 2'd0,
		ERR_NOT_PUBLISH = 2'd1,
		ERR_LEN_OVER    = 2'd2,
		ERR_TOPIC_LONG  = 2'd3
	} err_t;

endpackage

`default_nettype wire

// ----- design/mqtt_publish_packet_parser_top.sv -----
// Each accepted byte is registered straight into the result register.
// Throughput: one byte per cycle while the output is not stalled; the single
// result register frees itself whenever the downstream side takes its beat, so
// input and output overlap. The per-byte state update and all length sums fit
// between the state registers and the result register.
// Reset clears the parser state to idle and empties the result register.
`timescale 1ns / 1ps
`default_nettype none

// ----------------------------------------------------------------------------
// MQTT publish packet parser
// Classifies each byte of a QoS 0 publish packet, decodes the remaining
// length and topic length, and reports payload length and offset.
// ----------------------------------------------------------------------------
`include "mqtt_publish_packet_parser_top_defines.svh"

module mqtt_publish_packet_parser_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// rx_byte[7:0]
	input  wire logic [mqttpp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// packet_start[0]
	input  wire logic                                s_axis_tuser,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// data_byte[7:0], field_position[35:8], topic_length[51:36],
	// payload_length[79:52], payload_offset[108:80], error_code[110:109], zero[111]
	output logic [mqttpp_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
	// byte_kind[2:0]
	output logic [mqttpp_pkg::OUT_TUSER_W-1:0]       m_axis_tuser,
	// packet_end
	output logic                                     m_axis_tlast
);
	import mqttpp_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_LEN     = 3'd1,
		PH_TLEN_HI = 3'd2,
		PH_TLEN_LO = 3'd3,
		PH_TOPIC   = 3'd4,
		PH_PAYLOAD = 3'd5,
		PH_SKIP    = 3'd6
	} phase_t;

	phase_t       phase_q, phase_d;
	logic [27:0]  rem_len_q, rem_len_d;
	logic [2:0]   grp_cnt_q, grp_cnt_d;
	logic [15:0]  topic_len_q, topic_len_d;
	logic [27:0]  byte_cnt_q, byte_cnt_d;
	logic [2:0]   hdr_cnt_q, hdr_cnt_d;
	err_t         err_q, err_d;

	logic         accept;
	logic [7:0]   rx_byte;
	logic [27:0]  group_shifted;
	logic [27:0]  byte_cnt_inc;
	logic         body_done;
	logic [16:0]  need_q;
	logic [16:0]  need_d;
	kind_t        kind;
	logic [27:0]  pos;
	logic         pkt_end;
	logic [15:0]  tlen_out;
	logic [27:0]  plen_out;
	logic [28:0]  poff_out;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
	assign rx_byte       = s_axis_tdata;

	// Remaining length groups arrive least significant first.
	always_comb begin
		unique case (grp_cnt_q[1:0])
			2'd0:    group_shifted = {21'd0, rx_byte[6:0]};
			2'd1:    group_shifted = {14'd0, rx_byte[6:0], 7'd0};
			2'd2:    group_shifted = {7'd0, rx_byte[6:0], 14'd0};
			default: group_shifted = {rx_byte[6:0], 21'd0};
		endcase
	end

	assign byte_cnt_inc = byte_cnt_q + 28'd1;
	assign body_done    = byte_cnt_inc >= rem_len_q;
	assign need_q       = 17'd2 + {1'b0, topic_len_q};

	always_comb begin
		phase_d     = phase_q;
		rem_len_d   = rem_len_q;
		grp_cnt_d   = grp_cnt_q;
		topic_len_d = topic_len_q;
		byte_cnt_d  = byte_cnt_q;
		hdr_cnt_d   = hdr_cnt_q;
		err_d       = err_q;
		kind        = KIND_IGNORED;
		pos         = 28'd0;
		pkt_end     = 1'b0;
		if (s_axis_tuser) begin
			rem_len_d   = 28'd0;
			grp_cnt_d   = 3'd0;
			topic_len_d = 16'd0;
			byte_cnt_d  = 28'd0;
			hdr_cnt_d   = 3'd1;
			if (rx_byte == PUBLISH_HEADER) begin
				kind    = KIND_HEADER;
				err_d   = ERR_NONE;
				phase_d = PH_LEN;
			end else begin
				err_d   = ERR_NOT_PUBLISH;
				phase_d = PH_IDLE;
			end
		end else begin
			unique case (phase_q)
				PH_LEN: begin
					kind      = KIND_LENGTH;
					rem_len_d = rem_len_q | group_shifted;
					grp_cnt_d = grp_cnt_q + 3'd1;
					hdr_cnt_d = hdr_cnt_q + 3'd1;
					if (rx_byte[7]) begin
						if (grp_cnt_d >= MAX_LENGTH_BYTES) begin
							err_d   = ERR_LEN_OVER;
							phase_d = PH_IDLE;
						end
					end else if (rem_len_d == 28'd0) begin
						err_d   = ERR_TOPIC_LONG;
						pkt_end = 1'b1;
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_TLEN_HI;
					end
				end
				PH_TLEN_HI: begin
					kind        = KIND_TLEN;
					topic_len_d = {rx_byte, 8'd0};
					byte_cnt_d  = byte_cnt_inc;
					if (body_done) begin
						pkt_end = 1'b1;
						err_d   = ERR_TOPIC_LONG;
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_TLEN_LO;
					end
				end
				PH_TLEN_LO: begin
					kind        = KIND_TLEN;
					topic_len_d = {topic_len_q[15:8], rx_byte};
					byte_cnt_d  = byte_cnt_inc;
					// The remaining length is at least two on this path.
					if ({12'd0, topic_len_d} > rem_len_q - 28'd2) begin
						err_d = ERR_TOPIC_LONG;
					end
					if (body_done) begin
						pkt_end = 1'b1;
						phase_d = PH_IDLE;
					end else if (err_d != ERR_NONE) begin
						phase_d = PH_SKIP;
					end else if (topic_len_d != 16'd0) begin
						phase_d = PH_TOPIC;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
				PH_TOPIC: begin
					kind       = KIND_TOPIC;
					pos        = byte_cnt_q - 28'd2;
					byte_cnt_d = byte_cnt_inc;
					if (body_done) begin
						pkt_end = 1'b1;
						phase_d = PH_IDLE;
					end else if (byte_cnt_inc >= {11'd0, need_q}) begin
						phase_d = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					kind       = KIND_PAYLOAD;
					pos        = byte_cnt_q - {11'd0, need_q};
					byte_cnt_d = byte_cnt_inc;
					if (body_done) begin
						pkt_end = 1'b1;
						phase_d = PH_IDLE;
					end
				end
				PH_SKIP: begin
					byte_cnt_d = byte_cnt_inc;
					if (body_done) begin
						pkt_end = 1'b1;
						phase_d = PH_IDLE;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// Lengths are reported once both topic length bytes are in.
	assign need_d = 17'd2 + {1'b0, topic_len_d};

	always_comb begin
		tlen_out = 16'd0;
		plen_out = 28'd0;
		poff_out = 29'd0;
		if (byte_cnt_d >= 28'd2) begin
			tlen_out = topic_len_d;
			if (rem_len_d > {11'd0, need_d}) begin
				plen_out = rem_len_d - {11'd0, need_d};
			end
			poff_out = {26'd0, hdr_cnt_d} + {12'd0, need_d};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			rem_len_q     <= 28'd0;
			grp_cnt_q     <= 3'd0;
			topic_len_q   <= 16'd0;
			byte_cnt_q    <= 28'd0;
			hdr_cnt_q     <= 3'd0;
			err_q         <= ERR_NONE;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tuser  <= '0;
			m_axis_tlast  <= 1'b0;
		end else begin
			if (accept) begin
				phase_q       <= phase_d;
				rem_len_q     <= rem_len_d;
				grp_cnt_q     <= grp_cnt_d;
				topic_len_q   <= topic_len_d;
				byte_cnt_q    <= byte_cnt_d;
				hdr_cnt_q     <= hdr_cnt_d;
				err_q         <= err_d;
				m_axis_tvalid <= 1'b1;
				m_axis_tdata  <= {1'b0, err_d, poff_out, plen_out, tlen_out, pos, rx_byte};
				m_axis_tuser  <= kind;
				m_axis_tlast  <= pkt_end;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	`MQTTPP_ASSERT(a_end_not_rejected, m_axis_tvalid && m_axis_tlast, m_axis_tdata[110:109] != ERR_NOT_PUBLISH && m_axis_tdata[110:109] != ERR_LEN_OVER, "packet end flagged on a rejected packet")
	`MQTTPP_ASSERT(a_header_clean, m_axis_tvalid && m_axis_tuser == KIND_HEADER, m_axis_tdata[110:109] == ERR_NONE && !m_axis_tlast, "header beat carries an error or an end mark")
	`MQTTPP_ASSERT_NEXT(a_bad_header_idle, accept && s_axis_tuser && rx_byte != PUBLISH_HEADER, phase_q == PH_IDLE && err_q == ERR_NOT_PUBLISH, "rejected header did not return the parser to idle")
	`MQTTPP_ASSERT(a_active_no_reject, phase_q != PH_IDLE, err_q != ERR_NOT_PUBLISH && err_q != ERR_LEN_OVER, "parser active on a rejected packet")

endmodule

`default_nettype wire

// ----- verif/mqtt_publish_packet_parser_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MQTT publish packet parser testbench
// Streams received bytes into the parser, first from a short table of corner
// cases and then as random publish packets, broken packets and noise. A
// byte-level parser model in the bench predicts every output beat, and each
// beat is compared field by field. Both sides idle at random, and the output
// side holds off once for a long stretch so that the parser stalls its input.
// ----------------------------------------------------------------------------

module mqtt_publish_packet_parser_top_tb;
	import mqttpp_pkg::*;

	localparam int RANDOM_ITEMS = 1800;
	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PRINT_CAP    = 100;
	localparam logic [7:0] LEN_CONT  = 8'h80;
	localparam logic [7:0] LEN_GROUP = 8'h7F;

	typedef enum logic [2:0] {
		P_IDLE, P_LEN, P_TLEN_HI, P_TLEN_LO, P_TOPIC, P_PAYLOAD, P_SKIP
	} phase_t;

	// One input byte; kind, err and last are only meaningful when typed is set.
	typedef struct packed {
		logic [7:0] rx;
		logic       start;
		logic       typed;
		kind_t      kind;
		err_t       err;
		logic       last;
	} rx_row_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [27:0] pos;
		logic [15:0] tlen;
		logic [27:0] plen;
		logic [28:0] poff;
		err_t        err;
		logic        last;
	} parsed_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;
	logic        m_axis_tlast;

	// Parser model state.
	phase_t      parse_state = P_IDLE;
	logic [27:0] rem_len     = '0;
	logic [2:0]  len_groups  = '0;
	logic [15:0] topic_len   = '0;
	logic [27:0] body_count  = '0;
	logic [2:0]  hdr_count   = '0;
	err_t        pkt_err     = ERR_NONE;

	parsed_t pending_parsed[$];
	rx_row_t rx_rows[$];
	rx_row_t corner_rows [0:24];
	int      mismatches = 0;
	int      fed_count = 0;
	int      idle_cycles = 0;
	bit      calm = 1'b0;

	mqtt_publish_packet_parser_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit idle_now();
		return !calm && ($urandom_range(0, 99) < 31);
	endfunction

	task automatic note_mismatch(input string what, input longint got, input longint want);
		if (mismatches < PRINT_CAP)
			$display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	// Counts one byte after the length field; true on the last byte of the packet.
	function automatic bit take_body_byte();
		body_count = body_count + 28'd1;
		if (body_count >= rem_len) begin
			parse_state = P_IDLE;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic parsed_t parse_byte(input logic [7:0] b, input logic start);
		parsed_t r;
		logic [31:0] need;
		r.kind = KIND_IGNORED;
		r.data = b;
		r.pos = '0;
		r.last = 1'b0;
		if (start) begin
			rem_len = '0;
			len_groups = '0;
			topic_len = '0;
			body_count = '0;
			hdr_count = 3'd1;
			if (b == PUBLISH_HEADER) begin
				r.kind = KIND_HEADER;
				pkt_err = ERR_NONE;
				parse_state = P_LEN;
			end else begin
				pkt_err = ERR_NOT_PUBLISH;
				parse_state = P_IDLE;
			end
		end else begin
			case (parse_state)
				P_LEN: begin
					r.kind = KIND_LENGTH;
					// Least significant group first.
					rem_len = rem_len | (28'(b & LEN_GROUP) << (7 * len_groups[1:0]));
					len_groups = len_groups + 3'd1;
					hdr_count = hdr_count + 3'd1;
					if (b & LEN_CONT) begin
						if (len_groups >= MAX_LENGTH_BYTES) begin
							pkt_err = ERR_LEN_OVER;
							parse_state = P_IDLE;
						end
					end else if (rem_len == 0) begin
						pkt_err = ERR_TOPIC_LONG;
						r.last = 1'b1;
						parse_state = P_IDLE;
					end else begin
						parse_state = P_TLEN_HI;
					end
				end
				P_TLEN_HI: begin
					r.kind = KIND_TLEN;
					topic_len = {b, 8'h00};
					if (take_body_byte()) begin
						r.last = 1'b1;
						pkt_err = ERR_TOPIC_LONG;
					end else begin
						parse_state = P_TLEN_LO;
					end
				end
				P_TLEN_LO: begin
					r.kind = KIND_TLEN;
					topic_len = topic_len | 16'(b);
					if (32'(topic_len) + 32'd2 > 32'(rem_len))
						pkt_err = ERR_TOPIC_LONG;
					if (take_body_byte())
						r.last = 1'b1;
					else if (pkt_err != ERR_NONE)
						parse_state = P_SKIP;
					else
						parse_state = (topic_len != 0) ? P_TOPIC : P_PAYLOAD;
				end
				P_TOPIC: begin
					r.kind = KIND_TOPIC;
					r.pos = body_count - 28'd2;
					if (take_body_byte())
						r.last = 1'b1;
					else if (body_count >= 28'(topic_len) + 28'd2)
						parse_state = P_PAYLOAD;
				end
				P_PAYLOAD: begin
					r.kind = KIND_PAYLOAD;
					r.pos = body_count - 28'd2 - 28'(topic_len);
					if (take_body_byte())
						r.last = 1'b1;
				end
				P_SKIP: begin
					if (take_body_byte())
						r.last = 1'b1;
				end
				default: begin
					parse_state = P_IDLE;
				end
			endcase
		end
		r.tlen = '0;
		r.plen = '0;
		r.poff = '0;
		if (body_count >= 28'd2) begin
			need = 32'd2 + 32'(topic_len);
			r.tlen = topic_len;
			r.plen = (32'(rem_len) > need) ? 28'(32'(rem_len) - need) : '0;
			r.poff = 29'(hdr_count) + 29'd2 + 29'(topic_len);
		end
		r.err = pkt_err;
		return r;
	endfunction

	initial begin
		logic [7:0]  pkt[$];
		logic [7:0]  hdr;
		logic [7:0]  grp;
		logic [31:0] rl;
		logic [31:0] tl;
		logic [31:0] v;
		int          pick;
		int          ng;
		int          body;
		int          i;
		int          idx;
		rx_row_t     row;
		parsed_t     want;

		corner_rows = '{
			'{8'h00, 1'b0, 1'b1, KIND_IGNORED, ERR_NONE,        1'b0},
			'{8'hFF, 1'b1, 1'b1, KIND_IGNORED, ERR_NOT_PUBLISH, 1'b0},
			'{8'h30, 1'b1, 1'b1, KIND_HEADER,  ERR_NONE,        1'b0},
			'{8'h00, 1'b0, 1'b1, KIND_LENGTH,  ERR_TOPIC_LONG,  1'b1},
			'{8'h30, 1'b1, 1'b1, KIND_HEADER,  ERR_NONE,        1'b0},
			'{8'h01, 1'b0, 1'b1, KIND_LENGTH,  ERR_NONE,        1'b0},
			'{8'hFF, 1'b0, 1'b1, KIND_TLEN,    ERR_TOPIC_LONG,  1'b1},
			'{8'h30, 1'b1, 1'b1, KIND_HEADER,  ERR_NONE,        1'b0},
			'{8'hFF, 1'b0, 1'b1, KIND_LENGTH,  ERR_NONE,        1'b0},
			'{8'h80, 1'b0, 1'b1, KIND_LENGTH,  ERR_NONE,        1'b0},
			'{8'h80, 1'b0, 1'b1, KIND_LENGTH,  ERR_NONE,        1'b0},
			'{8'h80, 1'b0, 1'b1, KIND_LENGTH,  ERR_LEN_OVER,    1'b0},
			'{8'h00, 1'b0, 1'b1, KIND_IGNORED, ERR_LEN_OVER,    1'b0},
			'{8'h30, 1'b1, 1'b1, KIND_HEADER,  ERR_NONE,        1'b0},
			'{8'h04, 1'b0, 1'b1, KIND_LENGTH,  ERR_NONE,        1'b0},
			'{8'h00, 1'b0, 1'b1, KIND_TLEN,    ERR_NONE,        1'b0},
			'{8'h05, 1'b0, 1'b1, KIND_TLEN,    ERR_TOPIC_LONG,  1'b0},
			'{8'hAA, 1'b0, 1'b1, KIND_IGNORED, ERR_TOPIC_LONG,  1'b0},
			// New start before the skipped bytes run out.
			'{8'h30, 1'b1, 1'b1, KIND_HEADER,  ERR_NONE,        1'b0},
			'{8'h05, 1'b0, 1'b1, KIND_LENGTH,  ERR_NONE,        1'b0},
			'{8'h00, 1'b0, 1'b1, KIND_TLEN,    ERR_NONE,        1'b0},
			'{8'h01, 1'b0, 1'b1, KIND_TLEN,    ERR_NONE,        1'b0},
			'{8'h7E, 1'b0, 1'b0, KIND_IGNORED, ERR_NONE,        1'b0},
			'{8'h00, 1'b0, 1'b0, KIND_IGNORED, ERR_NONE,        1'b0},
			'{8'h81, 1'b0, 1'b0, KIND_IGNORED, ERR_NONE,        1'b0}
		};
		foreach (corner_rows[k])
			rx_rows.push_back(corner_rows[k]);

		while (rx_rows.size() < RANDOM_ITEMS + 25) begin
			pkt.delete();
			pick = $urandom_range(0, 99);
			if (pick < 86) begin
				if (pick < 64) begin
					// Well-formed publish with random content.
					tl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
					rl = 32'd2 + tl + $urandom_range(0, 12);
				end else if (pick < 74) begin
					rl = $urandom_range(2, 10);
					tl = $urandom_range(rl - 1, 65535);
				end else if (pick < 78) begin
					rl = $urandom_range(0, 1);
					tl = $urandom_range(0, 65535);
				end else begin
					// Huge remaining length; the packet is cut short by the next start.
					rl = ($urandom_range(0, 3) == 0) ? 32'h0FFF_FFFF : $urandom_range(0, 32'h0FFF_FFFF);
					tl = $urandom_range(0, 65535);
				end
				pkt.push_back(PUBLISH_HEADER);
				ng = 1;
				v = rl >> 7;
				while (v != 0) begin
					ng++;
					v = v >> 7;
				end
				// Now and then pad the length field with empty groups.
				if (ng < 4 && $urandom_range(0, 7) == 0)
					ng = $urandom_range(ng, 4);
				v = rl;
				for (i = 0; i < ng; i++) begin
					grp = v[7:0] & LEN_GROUP;
					v = v >> 7;
					if (i < ng - 1)
						grp = grp | LEN_CONT;
					pkt.push_back(grp);
				end
				if (rl >= 1)
					pkt.push_back(tl[15:8]);
				if (rl >= 2)
					pkt.push_back(tl[7:0]);
				body = (rl > 2) ? int'(rl - 2) : 0;
				if (body > 64)
					body = $urandom_range(0, 40);
				for (i = 0; i < body; i++)
					pkt.push_back($urandom_range(0, 255));
				if (pick < 64 && pkt.size() > 2 && $urandom_range(0, 19) == 0)
					pkt = pkt[0:$urandom_range(1, pkt.size() - 2)];
			end else if (pick < 92) begin
				pkt.push_back(PUBLISH_HEADER);
				for (i = 0; i < 4; i++)
					pkt.push_back($urandom_range(128, 255));
				for (i = $urandom_range(0, 4); i > 0; i--)
					pkt.push_back($urandom_range(0, 255));
			end else begin
				do
					hdr = $urandom_range(0, 255);
				while (hdr == PUBLISH_HEADER);
				pkt.push_back(hdr);
				for (i = $urandom_range(0, 6); i > 0; i--)
					pkt.push_back($urandom_range(0, 255));
			end
			// Stray bytes between packets.
			if ($urandom_range(0, 9) == 0)
				for (i = $urandom_range(1, 3); i > 0; i--)
					pkt.push_back($urandom_range(0, 255));
			foreach (pkt[k]) begin
				row = '0;
				row.rx = pkt[k];
				row.start = (k == 0);
				rx_rows.push_back(row);
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		idx = 0;
		while (idx < rx_rows.size()) begin
			@(posedge clk);
			if (s_axis_tvalid && s_axis_tready) begin
				want = parse_byte(s_axis_tdata, s_axis_tuser);
				row = rx_rows[idx];
				if (row.typed) begin
					want.kind = row.kind;
					want.err = row.err;
					want.last = row.last;
				end
				pending_parsed.push_back(want);
				idx++;
				fed_count = idx;
			end
			calm = (idx >= 900 && idx < 1250);
			if (idx == rx_rows.size()) begin
				s_axis_tvalid <= 1'b0;
			end else if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (idle_now()) begin
					s_axis_tvalid <= 1'b0;
				end else begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= rx_rows[idx].rx;
					s_axis_tuser <= rx_rows[idx].start;
				end
			end
		end

		while (pending_parsed.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Output side; holds off once for a long stretch so the parser backs up.
	initial begin
		int  hold_left;
		bit  held;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (!held && fed_count >= 400) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= !idle_now();
			end
		end
	end

	always @(posedge clk) begin
		parsed_t want;
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_parsed.size() == 0) begin
					note_mismatch("beat with nothing expected", m_axis_tdata[7:0], 0);
				end else begin
					want = pending_parsed.pop_front();
					if (m_axis_tuser !== want.kind)
						note_mismatch("byte_kind", m_axis_tuser, want.kind);
					if (m_axis_tdata[7:0] !== want.data)
						note_mismatch("data_byte", m_axis_tdata[7:0], want.data);
					if (m_axis_tdata[35:8] !== want.pos)
						note_mismatch("field_position", m_axis_tdata[35:8], want.pos);
					if (m_axis_tdata[51:36] !== want.tlen)
						note_mismatch("topic_length", m_axis_tdata[51:36], want.tlen);
					if (m_axis_tdata[79:52] !== want.plen)
						note_mismatch("payload_length", m_axis_tdata[79:52], want.plen);
					if (m_axis_tdata[108:80] !== want.poff)
						note_mismatch("payload_offset", m_axis_tdata[108:80], want.poff);
					if (m_axis_tdata[110:109] !== want.err)
						note_mismatch("error_code", m_axis_tdata[110:109], want.err);
					if (m_axis_tlast !== want.last)
						note_mismatch("packet_end", m_axis_tlast, want.last);
				end
			end
		end
	end

endmodule
